/* hw/rtl/spq_pkg.sv */
// shared types and codes for the sorted priority queue
package spq_pkg;

  localparam int ID_W   = 16;
  localparam int PRIO_W = 8;
  localparam int OCC_W  = 5;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_PRI = 2'd1,
    OP_REMOVE_MAX = 2'd2,
    OP_CLEAR      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REMOVED = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
  } cmd_t;

endpackage

/* hw/rtl/spq_front.sv */
// input side: takes items, decodes them into commands, holds them in a two-entry queue
module spq_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output spq_pkg::cmd_t       cmd_o
);

  spq_pkg::cmd_t buf_q [2];
  logic          wr_q, wr_d;
  logic          rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;
  spq_pkg::cmd_t in_cmd;
  logic          push, pop;

  always_comb begin
    in_cmd.op   = spq_pkg::op_e'(s_axis_tuser);
    in_cmd.id   = s_axis_tdata[spq_pkg::ID_W-1:0];
    in_cmd.prio = s_axis_tdata[spq_pkg::ID_W +: spq_pkg::PRIO_W];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign cmd_o         = buf_q[rd_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= in_cmd;
    end
  end

endmodule

/* hw/rtl/spq_back.sv */
// execution side: sorted row of slots, removal sequencer and output register
module spq_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  spq_pkg::cmd_t                 cmd_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic [1:0]                    m_axis_tuser
);

  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int EW = (FW > spq_pkg::OCC_W) ? FW : spq_pkg::OCC_W;
  localparam int PAD_W = 32 - spq_pkg::ID_W - spq_pkg::PRIO_W - spq_pkg::OCC_W;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_REMOVE = 1'b1;

  logic [spq_pkg::ID_W-1:0]   slot_id_q   [QUEUE_DEPTH];
  logic [spq_pkg::ID_W-1:0]   slot_id_d   [QUEUE_DEPTH];
  logic [spq_pkg::PRIO_W-1:0] slot_prio_q [QUEUE_DEPTH];
  logic [spq_pkg::PRIO_W-1:0] slot_prio_d [QUEUE_DEPTH];
  logic [FW-1:0]              fill_q, fill_d;
  logic [spq_pkg::PRIO_W-1:0] target_q, target_d;
  logic                       state_q, state_d;

  logic                       out_valid_q, out_valid_d;
  logic [spq_pkg::ID_W-1:0]   out_id_q, out_id_d;
  logic [spq_pkg::PRIO_W-1:0] out_prio_q, out_prio_d;
  spq_pkg::status_e           out_status_q, out_status_d;
  logic                       out_last_q, out_last_d;
  logic [FW-1:0]              out_occ_q, out_occ_d;
  logic [EW-1:0]              occ_ext;

  logic [QUEUE_DEPTH-1:0]     valid_vec, match, first, lastm, top, stay;
  logic [IW-1:0]              lo_idx, hi_idx;
  logic [FW-1:0]              run_len, occ_rm;
  logic [spq_pkg::ID_W-1:0]   sel_id;
  logic [spq_pkg::PRIO_W-1:0] sel_prio, top_prio;
  logic                       is_last, can_emit;

  assign can_emit    = !out_valid_q || m_axis_tready;
  assign cmd_ready_o = (state_q == S_IDLE) && can_emit;

  always_comb begin
    valid_vec = '0;
    match     = '0;
    stay      = '0;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      valid_vec[j] = FW'(j) < fill_q;
      match[j]     = valid_vec[j] && (slot_prio_q[j] == target_q);
      stay[j]      = valid_vec[j] && (slot_prio_q[j] <= cmd_i.prio);
    end
    first = match & ~(match << 1);
    lastm = match & ~(match >> 1);
    top   = valid_vec & ~(valid_vec >> 1);
  end

  always_comb begin
    lo_idx   = '0;
    hi_idx   = '0;
    sel_id   = '0;
    sel_prio = '0;
    top_prio = '0;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      lo_idx   = lo_idx | (first[j] ? IW'(j) : '0);
      hi_idx   = hi_idx | (lastm[j] ? IW'(j) : '0);
      sel_id   = sel_id | (first[j] ? slot_id_q[j] : '0);
      sel_prio = sel_prio | (first[j] ? slot_prio_q[j] : '0);
      top_prio = top_prio | (top[j] ? slot_prio_q[j] : '0);
    end
    run_len = FW'(hi_idx) - FW'(lo_idx) + FW'(1);
    occ_rm  = fill_q - run_len;
    is_last = (first & (match >> 1)) == '0;
  end

  always_comb begin
    slot_id_d    = slot_id_q;
    slot_prio_d  = slot_prio_q;
    fill_d       = fill_q;
    target_d     = target_q;
    state_d      = state_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_id_d     = out_id_q;
    out_prio_d   = out_prio_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    out_occ_d    = out_occ_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && can_emit) begin
          unique case (cmd_i.op)
            spq_pkg::OP_INSERT: begin
              out_valid_d = 1'b1;
              out_id_d    = '0;
              out_prio_d  = '0;
              out_last_d  = 1'b1;
              if (fill_q == FW'(QUEUE_DEPTH)) begin
                out_status_d = spq_pkg::ST_FULL;
                out_occ_d    = fill_q;
              end else begin
                if (!stay[0]) begin
                  slot_id_d[0]   = cmd_i.id;
                  slot_prio_d[0] = cmd_i.prio;
                end
                for (int j = 1; j < QUEUE_DEPTH; j++) begin
                  if (!stay[j]) begin
                    slot_id_d[j]   = stay[j-1] ? cmd_i.id : slot_id_q[j-1];
                    slot_prio_d[j] = stay[j-1] ? cmd_i.prio : slot_prio_q[j-1];
                  end
                end
                fill_d       = fill_q + FW'(1);
                out_status_d = spq_pkg::ST_OK;
                out_occ_d    = fill_q + FW'(1);
              end
            end
            spq_pkg::OP_REMOVE_PRI: begin
              target_d = cmd_i.prio;
              state_d  = S_REMOVE;
            end
            spq_pkg::OP_REMOVE_MAX: begin
              target_d = top_prio;
              state_d  = S_REMOVE;
            end
            spq_pkg::OP_CLEAR: begin
              fill_d       = '0;
              out_valid_d  = 1'b1;
              out_id_d     = '0;
              out_prio_d   = '0;
              out_status_d = spq_pkg::ST_OK;
              out_last_d   = 1'b1;
              out_occ_d    = '0;
            end
            default: ;
          endcase
        end
      end
      S_REMOVE: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          if (match == '0) begin
            out_id_d     = '0;
            out_prio_d   = '0;
            out_status_d = spq_pkg::ST_NONE;
            out_last_d   = 1'b1;
            out_occ_d    = fill_q;
            state_d      = S_IDLE;
          end else begin
            out_id_d     = sel_id;
            out_prio_d   = sel_prio;
            out_status_d = spq_pkg::ST_REMOVED;
            out_last_d   = is_last;
            out_occ_d    = occ_rm;
            for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
              if (IW'(j) >= lo_idx) begin
                slot_id_d[j]   = slot_id_q[j+1];
                slot_prio_d[j] = slot_prio_q[j+1];
              end
            end
            fill_d = fill_q - FW'(1);
            if (is_last) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_id_q    <= slot_id_d;
    slot_prio_q  <= slot_prio_d;
    target_q     <= target_d;
    out_id_q     <= out_id_d;
    out_prio_q   <= out_prio_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
    out_occ_q    <= out_occ_d;
  end

  assign occ_ext       = EW'(out_occ_q);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, occ_ext[spq_pkg::OCC_W-1:0], out_prio_q, out_id_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// sorted priority queue top level: decode queue in front of the slot row
//
//   channel   dir   tdata (low bit up)                         tuser      tlast
//   s_axis    in    item_id[15:0] priority_req[23:16]           operation  -
//   m_axis    out   out_id[15:0] out_priority[23:16] occ[28:24] status     last
//
// insert and clear pass through the decode queue, then are handled in the slot row
// a removal latches its target, then removes one matching entry per cycle while
// the output can take it (a miss gives one none reply); the slot row shift sets this pace
// reset empties the queue; slot contents are not cleared
// the decode queue keeps accepting, until both its entries are full, while the slot row waits on a stalled output
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // item_id, priority_req
  input  logic [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_id, out_priority, occupancy
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser    // status
);

  logic          cmd_valid;
  logic          cmd_ready;
  spq_pkg::cmd_t cmd;

  spq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  spq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
